[rtl/sha256sh_pkg.sv]
// Shared types, constants and round constants of the SHA-256 stream hash core.
package sha256sh_pkg;

   localparam int unsigned NUM_WORDS  = 8;
   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned SCHED_LEN  = 16;

   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [63:0] BYTE_BITS    = 64'd8;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Controls handed from the sequencer to the round unit.
   typedef struct packed {
      logic       load;
      logic       step;
      logic       shift;
      logic [7:0] shift_byte;
   } rnd_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_SEND
   } state_type;

   localparam logic [31:0] INIT_HASH [NUM_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

[rtl/sha256sh_round.sv]
// Shared SHA-256 round unit: working variables, schedule shift line and one round.
module sha256sh_round (
   input  logic                        clock,
   input  sha256sh_pkg::rnd_ctrl_type  ctrl,
   input  logic [5:0]                  round_idx,
   input  logic [31:0]                 chain_words [sha256sh_pkg::NUM_WORDS],
   output logic [31:0]                 work_words  [sha256sh_pkg::NUM_WORDS]
);

   logic [31:0] work_ff  [sha256sh_pkg::NUM_WORDS];
   logic [31:0] work_in  [sha256sh_pkg::NUM_WORDS];
   logic [31:0] sched_ff [sha256sh_pkg::SCHED_LEN];
   logic [31:0] sched_in [sha256sh_pkg::SCHED_LEN];

   logic [31:0] sig0, sig1, w_next;
   logic [31:0] big0, big1, choose, major, t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      sig0   = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      sig1   = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      // Word sixteen rounds ahead of the one in use now.
      w_next = sig1 + sched_ff[9] + sig0 + sched_ff[0];

      big1   = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + big1 + choose + sha256sh_pkg::ROUND_K[round_idx] + sched_ff[0];
      big0   = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
               (work_ff[1] & work_ff[2]);
      t2     = big0 + major;

      work_in  = work_ff;
      sched_in = sched_ff;

      if (ctrl.load) begin
         work_in = chain_words;
      end else if (ctrl.step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         for (int i = 0; i < sha256sh_pkg::SCHED_LEN - 1; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[sha256sh_pkg::SCHED_LEN - 1] = w_next;
      end

      // The schedule line doubles as the block buffer: bytes enter at the
      // low byte of the last word so that the first byte of the block ends up in word zero.
      if (ctrl.shift) begin
         for (int i = 0; i < sha256sh_pkg::SCHED_LEN - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i + 1][31:24]};
         end
         sched_in[sha256sh_pkg::SCHED_LEN - 1] =
            {sched_ff[sha256sh_pkg::SCHED_LEN - 1][23:0], ctrl.shift_byte};
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign work_words = work_ff;

endmodule

[rtl/sha256_stream_hash_core.sv]
// Top level of the SHA-256 stream hash core: sequencer, chaining words and bit count.
//
//   channel | direction | payload                                  | handshake
//   req_    | in        | data_byte, byte_present, message_end     | req_valid / req_ready
//   rsp_    | out       | digest_word, word_index, last_word       | rsp_valid / rsp_ready
//
// The byte that fills a 64-byte block starts a compression: load, 64 rounds in
// the single shared round unit, and the fold. A message end then shifts in the
// padding and length bytes up to the block end, runs one or two compressions,
// and then sends eight result transactions.
// Reset is synchronous; it restores the initial hash values and a zero bit count.
// req_ready is high only while the sequencer waits for input; rsp_ready stalls
// hold the current digest word until it is taken.
module sha256_stream_hash_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sha256sh_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sha256sh_pkg::rsp_type  rsp_data
);

   sha256sh_pkg::state_type    state_ff, state_in;
   sha256sh_pkg::rnd_ctrl_type rnd_ctrl;

   logic [31:0] chain_ff [sha256sh_pkg::NUM_WORDS];
   logic [31:0] chain_in [sha256sh_pkg::NUM_WORDS];
   logic [31:0] work_words [sha256sh_pkg::NUM_WORDS];

   logic [63:0] bit_len_ff, bit_len_in;
   logic [63:0] len_shift;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  pos_ff, pos_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        end_pend_ff, end_pend_in;
   logic        mark_done_ff, mark_done_in;
   logic        len_done_ff, len_done_in;

   sha256sh_round u_round (
      .clock       (clock),
      .ctrl        (rnd_ctrl),
      .round_idx   (round_ff),
      .chain_words (chain_ff),
      .work_words  (work_words)
   );

   // Length bytes go out most significant first.
   assign len_shift = bit_len_ff << {pos_ff[2:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      bit_len_in   = bit_len_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      out_idx_in   = out_idx_ff;
      end_pend_in  = end_pend_ff;
      mark_done_in = mark_done_ff;
      len_done_in  = len_done_ff;
      rnd_ctrl     = '0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      case (state_ff)
         sha256sh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               end_pend_in  = req_data.message_end;
               mark_done_in = 1'b0;
               len_done_in  = 1'b0;
               if (req_data.byte_present) begin
                  rnd_ctrl.shift      = 1'b1;
                  rnd_ctrl.shift_byte = req_data.data_byte;
                  bit_len_in          = bit_len_ff + sha256sh_pkg::BYTE_BITS;
                  pos_in              = pos_ff + 6'd1;
                  if (pos_ff == sha256sh_pkg::LAST_POS) begin
                     state_in = sha256sh_pkg::ST_LOAD;
                  end else if (req_data.message_end) begin
                     state_in = sha256sh_pkg::ST_PAD_MARK;
                  end
               end else if (req_data.message_end) begin
                  state_in = sha256sh_pkg::ST_PAD_MARK;
               end
            end
         end
         sha256sh_pkg::ST_LOAD: begin
            rnd_ctrl.load = 1'b1;
            round_in      = '0;
            state_in      = sha256sh_pkg::ST_ROUND;
         end
         sha256sh_pkg::ST_ROUND: begin
            rnd_ctrl.step = 1'b1;
            round_in      = round_ff + 6'd1;
            if (round_ff == sha256sh_pkg::LAST_ROUND) begin
               state_in = sha256sh_pkg::ST_FOLD;
            end
         end
         sha256sh_pkg::ST_FOLD: begin
            for (int i = 0; i < sha256sh_pkg::NUM_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + work_words[i];
            end
            if (!end_pend_ff) begin
               state_in = sha256sh_pkg::ST_IDLE;
            end else if (len_done_ff) begin
               out_idx_in = '0;
               state_in   = sha256sh_pkg::ST_SEND;
            end else if (mark_done_ff) begin
               state_in = sha256sh_pkg::ST_PAD_ZERO;
            end else begin
               state_in = sha256sh_pkg::ST_PAD_MARK;
            end
         end
         sha256sh_pkg::ST_PAD_MARK: begin
            rnd_ctrl.shift      = 1'b1;
            rnd_ctrl.shift_byte = sha256sh_pkg::PAD_MARK_BYTE;
            mark_done_in        = 1'b1;
            pos_in              = pos_ff + 6'd1;
            if (pos_ff == sha256sh_pkg::LAST_POS) begin
               state_in = sha256sh_pkg::ST_LOAD;
            end else begin
               state_in = sha256sh_pkg::ST_PAD_ZERO;
            end
         end
         sha256sh_pkg::ST_PAD_ZERO: begin
            if (pos_ff == sha256sh_pkg::LEN_POS) begin
               state_in = sha256sh_pkg::ST_PAD_LEN;
            end else begin
               rnd_ctrl.shift      = 1'b1;
               rnd_ctrl.shift_byte = '0;
               pos_in              = pos_ff + 6'd1;
               if (pos_ff == sha256sh_pkg::LAST_POS) begin
                  state_in = sha256sh_pkg::ST_LOAD;
               end
            end
         end
         sha256sh_pkg::ST_PAD_LEN: begin
            rnd_ctrl.shift      = 1'b1;
            rnd_ctrl.shift_byte = len_shift[63:56];
            pos_in              = pos_ff + 6'd1;
            if (pos_ff == sha256sh_pkg::LAST_POS) begin
               len_done_in = 1'b1;
               state_in    = sha256sh_pkg::ST_LOAD;
            end
         end
         sha256sh_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == sha256sh_pkg::LAST_WORD_IDX) begin
                  // Digest fully delivered: start the next message afresh.
                  chain_in    = sha256sh_pkg::INIT_HASH;
                  bit_len_in  = '0;
                  end_pend_in = 1'b0;
                  state_in    = sha256sh_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha256sh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha256sh_pkg::ST_IDLE;
         chain_ff     <= sha256sh_pkg::INIT_HASH;
         bit_len_ff   <= '0;
         round_ff     <= '0;
         pos_ff       <= '0;
         out_idx_ff   <= '0;
         end_pend_ff  <= 1'b0;
         mark_done_ff <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         bit_len_ff   <= bit_len_in;
         round_ff     <= round_in;
         pos_ff       <= pos_in;
         out_idx_ff   <= out_idx_in;
         end_pend_ff  <= end_pend_in;
         mark_done_ff <= mark_done_in;
         len_done_ff  <= len_done_in;
      end
   end

   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == sha256sh_pkg::LAST_WORD_IDX);

   // The core never takes input while a digest is being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while digest pending");

   // The final digest word restarts the message state.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_word) |=>
         (bit_len_ff == '0 && state_ff == sha256sh_pkg::ST_IDLE))
      else $error("message state not restarted after digest");

   // The last round always hands over to the fold.
   a_round_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256sh_pkg::ST_ROUND && round_ff == sha256sh_pkg::LAST_ROUND) |=>
         state_ff == sha256sh_pkg::ST_FOLD)
      else $error("compression did not end after the last round");

   // Length bytes only occupy the last eight byte slots of a block.
   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256sh_pkg::ST_PAD_LEN |-> pos_ff >= sha256sh_pkg::LEN_POS)
      else $error("length byte outside its slot");

   // Byte position stays in step with the bit count while taking input.
   a_pos_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256sh_pkg::ST_IDLE |-> pos_ff == bit_len_ff[8:3])
      else $error("byte position out of step with bit count");

endmodule

[bench/sha256_stream_hash_core_tb.sv]
// Self-checking testbench for the SHA-256 stream hash core with its own digest predictor.
module sha256_stream_hash_core_tb;

   localparam int          ITEM_TARGET  = 350;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          REPORT_LIMIT = 10;
   localparam int          CHUNK_BYTES  = 64;
   localparam int          LEN_FIELD    = 56;
   localparam logic [7:0]  PAD_BYTE     = 8'h80;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   sha256sh_pkg::req_type req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   sha256sh_pkg::rsp_type rsp_data;

   // Predictor state: chaining words, partial block and message bit count.
   logic [31:0]           hash_chain [8];
   logic [7:0]            block_buf [CHUNK_BYTES];
   logic [63:0]           msg_bits;
   sha256sh_pkg::rsp_type digest_queue [$];

   int  fail_count;
   int  item_count;
   int  message_count;
   int  byte_count;
   int  words_checked;
   bit  steady;

   sha256_stream_hash_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_chunk();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      int r;
      for (r = 0; r < 16; r++) begin
         w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end
      for (r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      for (r = 0; r < 8; r++) begin
         v[r] = hash_chain[r];
      end
      for (r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (r = 0; r < 8; r++) begin
         hash_chain[r] = hash_chain[r] + v[r];
      end
   endfunction

   // Absorbs one accepted transaction; a message end queues the eight digest words.
   function automatic void hash_item(input sha256sh_pkg::req_type item);
      int                    fill;
      int                    i;
      sha256sh_pkg::rsp_type word;
      fill = int'(msg_bits[8:3]);
      if (item.byte_present) begin
         block_buf[fill] = item.data_byte;
         msg_bits = msg_bits + BITS_PER_BYTE;
         fill = (fill + 1) % CHUNK_BYTES;
         if (fill == 0) begin
            compress_chunk();
         end
      end
      if (!item.message_end) begin
         return;
      end
      block_buf[fill] = PAD_BYTE;
      fill = fill + 1;
      // No room for the length field: pad out this block and use one more.
      if (fill > LEN_FIELD) begin
         while (fill < CHUNK_BYTES) begin
            block_buf[fill] = 8'h00;
            fill = fill + 1;
         end
         compress_chunk();
         fill = 0;
      end
      while (fill < LEN_FIELD) begin
         block_buf[fill] = 8'h00;
         fill = fill + 1;
      end
      for (i = 0; i < 8; i++) begin
         block_buf[LEN_FIELD + i] = msg_bits[63 - 8*i -: 8];
      end
      compress_chunk();
      for (i = 0; i < 8; i++) begin
         word.digest_word = hash_chain[i];
         word.word_index  = 3'(i);
         word.last_word   = (i == 7);
         digest_queue.push_back(word);
      end
      hash_chain = SHA_H0;
      msg_bits   = '0;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic report_fail(input string text);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%s", text);
      end
   endtask

   // Drives one transaction at the falling edge and holds it until accepted.
   task automatic send_item(input sha256sh_pkg::req_type item);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      hash_item(item);
      if (item.byte_present || item.message_end) begin
         item_count++;
      end
      if (item.byte_present) begin
         byte_count++;
      end
      @(negedge clock);
   endtask

   task automatic send_idle();
      sha256sh_pkg::req_type item;
      item.data_byte    = 8'($urandom);
      item.byte_present = 1'b0;
      item.message_end  = 1'b0;
      send_item(item);
   endtask

   // Sends a message of random bytes, ending on the last byte or with a separate empty end.
   task automatic send_message(input int len, input bit end_on_byte);
      sha256sh_pkg::req_type item;
      int                    k;
      steady = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_idle();
         end
         item.data_byte    = 8'($urandom);
         item.byte_present = 1'b1;
         item.message_end  = end_on_byte && (k == len - 1);
         send_item(item);
      end
      if (!end_on_byte || len == 0) begin
         item.data_byte    = 8'($urandom);
         item.byte_present = 1'b0;
         item.message_end  = 1'b1;
         send_item(item);
      end
      message_count++;
      steady = 1'b0;
   endtask

   task automatic send_fixed(input logic [7:0] data, input bit present, input bit last);
      sha256sh_pkg::req_type item;
      item.data_byte    = data;
      item.byte_present = present;
      item.message_end  = last;
      send_item(item);
   endtask

   // Empty messages, an ignored idle transaction, single extreme bytes, "abc" and a two-byte message ended separately.
   task automatic test_short_messages();
      send_fixed(8'h00, 1'b0, 1'b1);
      send_fixed(8'hff, 1'b0, 1'b0);
      send_fixed(8'hff, 1'b0, 1'b1);
      send_fixed(8'h00, 1'b1, 1'b1);
      send_fixed(8'hff, 1'b1, 1'b1);
      send_fixed(8'h61, 1'b1, 1'b0);
      send_fixed(8'h62, 1'b1, 1'b0);
      send_fixed(8'h63, 1'b1, 1'b1);
      send_fixed(8'h80, 1'b1, 1'b0);
      send_fixed(8'h7f, 1'b1, 1'b0);
      send_fixed(8'h00, 1'b0, 1'b1);
      message_count += 6;
   endtask

   // Lengths where the padding just fits, just spills, and a full block before the end.
   task automatic test_block_boundaries();
      send_message(55, 1'b1);
      send_message(56, 1'b1);
      send_message(64, 1'b0);
   endtask

   task automatic test_random_messages();
      int roll;
      int len;
      while (item_count < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            len = $urandom_range(0, 8);
         end else if (roll < 90) begin
            len = $urandom_range(9, 40);
         end else begin
            len = $urandom_range(50, 70);
         end
         send_message(len, $urandom_range(0, 2) != 0);
      end
   endtask

   // Result side: random stalls, mostly short, some long, with stall-free stretches.
   initial begin
      int hold;
      int roll;
      rsp_ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               rsp_ready = 1'b1;
               hold = $urandom_range(40, 100);
            end else if (roll < 65) begin
               rsp_ready = 1'b1;
               hold = $urandom_range(0, 6);
            end else begin
               rsp_ready = 1'b0;
               hold = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      sha256sh_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_queue.size() == 0) begin
            report_fail($sformatf("unexpected digest word %h index %0d last %0b",
               rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word));
         end else begin
            want = digest_queue.pop_front();
            words_checked++;
            if (rsp_data.digest_word !== want.digest_word
                || rsp_data.word_index !== want.word_index
                || rsp_data.last_word !== want.last_word) begin
               report_fail($sformatf(
                  "digest word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                  want.digest_word, want.word_index, want.last_word,
                  rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word));
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      steady        = 1'b0;
      fail_count    = 0;
      item_count    = 0;
      message_count = 0;
      byte_count    = 0;
      words_checked = 0;
      hash_chain    = SHA_H0;
      msg_bits      = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_short_messages();
      test_block_boundaries();
      test_random_messages();
      req_valid = 1'b0;

      while (digest_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages (%0d bytes, %0d transactions), checked %0d digest words.",
         message_count, byte_count, item_count, words_checked);
      if (fail_count == 0) begin
         $display("sha256_stream_hash_core: match");
      end else begin
         $display("%0d failures", fail_count);
         $display("sha256_stream_hash_core: mismatch");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d digest words outstanding.", digest_queue.size());
      $display("sha256_stream_hash_core: mismatch");
      $finish;
   end

endmodule

[sim.f]
rtl/sha256sh_pkg.sv
rtl/sha256sh_round.sv
rtl/sha256_stream_hash_core.sv
bench/sha256_stream_hash_core_tb.sv
